>>> sv/rsa_pkg.sv
`timescale 1ns / 1ps
// rsa_pkg: shared constants, op and status codes, transaction structs
// for the RPN stack calculator. No dependencies.
package rsa_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = 9;
  localparam int DATA_W      = 32;

  localparam logic [3:0] OP_PUSH = 4'd0;
  localparam logic [3:0] OP_NOT  = 4'd1;
  localparam logic [3:0] OP_XOR  = 4'd2;
  localparam logic [3:0] OP_OR   = 4'd3;
  localparam logic [3:0] OP_AND  = 4'd4;
  localparam logic [3:0] OP_MOD  = 4'd5;
  localparam logic [3:0] OP_DIV  = 4'd6;
  localparam logic [3:0] OP_MUL  = 4'd7;
  localparam logic [3:0] OP_POW  = 4'd8;
  localparam logic [3:0] OP_INC  = 4'd9;
  localparam logic [3:0] OP_DEC  = 4'd10;
  localparam logic [3:0] OP_SUB  = 4'd11;
  localparam logic [3:0] OP_ADD  = 4'd12;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNDER   = 2'd1;
  localparam logic [1:0] ST_OVER    = 2'd2;
  localparam logic [1:0] ST_DIVZERO = 2'd3;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] literal;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] top;
    logic [8:0]         depth;
    logic [1:0]         status;
  } res_t;

  typedef struct packed {
    logic       go;
    logic [3:0] op;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] value;
  } alu_rsp_t;

endpackage

>>> sv/rsa_ram.sv
`timescale 1ns / 1ps
// rsa_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module rsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/rsa_alu.sv
`timescale 1ns / 1ps
// rsa_alu: operation unit; logic ops, inc, dec, add, sub and multiply from idle,
// iterative divide (32 steps) and square-and-multiply power. Uses rsa_pkg.
module rsa_alu (
  input  logic                     clk,
  input  logic                     rst,
  input  rsa_pkg::alu_req_t        req,
  input  logic [31:0]              lhs,
  input  logic [31:0]              rhs,
  output rsa_pkg::alu_rsp_t        rsp
);
  import rsa_pkg::*;

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_DIV  = 2'd1;
  localparam logic [1:0] A_POW  = 2'd2;
  localparam logic [1:0] A_FIX  = 2'd3;

  logic [1:0]  state;
  logic [32:0] rem;
  logic [31:0] quo, dvs, acc, base, expo, value;
  logic [4:0]  cnt;
  logic        neg_q, neg_r, is_mod, done;

  logic [32:0] rem_sh, trial;
  logic [63:0] prod, p_acc, p_base;
  logic [31:0] mag_l, mag_r;

  assign mag_l  = lhs[31] ? (32'd0 - lhs) : lhs;
  assign mag_r  = rhs[31] ? (32'd0 - rhs) : rhs;
  assign prod   = {32'd0, lhs} * {32'd0, rhs};
  assign p_acc  = {32'd0, acc} * {32'd0, base};
  assign p_base = {32'd0, base} * {32'd0, base};
  assign rem_sh = {rem[31:0], quo[31]};
  assign trial  = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= A_IDLE;
    end else begin
      unique case (state)
        A_IDLE: begin
          if (req.go) begin
            case (req.op)
              OP_NOT: begin value <= ~rhs;        done <= 1'b1; end
              OP_INC: begin value <= rhs + 32'd1; done <= 1'b1; end
              OP_DEC: begin value <= rhs - 32'd1; done <= 1'b1; end
              OP_XOR: begin value <= lhs ^ rhs;   done <= 1'b1; end
              OP_OR:  begin value <= lhs | rhs;   done <= 1'b1; end
              OP_AND: begin value <= lhs & rhs;   done <= 1'b1; end
              OP_SUB: begin value <= lhs - rhs;   done <= 1'b1; end
              OP_ADD: begin value <= lhs + rhs;   done <= 1'b1; end
              OP_MUL: begin value <= prod[31:0];  done <= 1'b1; end
              OP_DIV, OP_MOD: begin
                quo    <= mag_l;
                dvs    <= mag_r;
                rem    <= 33'd0;
                cnt    <= 5'd0;
                neg_q  <= lhs[31] ^ rhs[31];
                neg_r  <= lhs[31];
                is_mod <= (req.op == OP_MOD);
                state  <= A_DIV;
              end
              OP_POW: begin
                if (rhs[31]) begin
                  // negative exponent: only bases 1 and -1 survive
                  if (lhs == 32'd1) begin
                    value <= 32'd1;
                  end else if (lhs == 32'hFFFF_FFFF) begin
                    value <= rhs[0] ? 32'hFFFF_FFFF : 32'd1;
                  end else begin
                    value <= 32'd0;
                  end
                  done <= 1'b1;
                end else begin
                  acc   <= 32'd1;
                  base  <= lhs;
                  expo  <= rhs;
                  state <= A_POW;
                end
              end
              default: begin value <= 32'd0; done <= 1'b1; end
            endcase
          end
        end
        A_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (!trial[32]) begin
            rem <= trial;
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[30:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= A_FIX;
          end
        end
        A_FIX: begin
          if (is_mod) begin
            value <= neg_r ? (32'd0 - rem[31:0]) : rem[31:0];
          end else begin
            value <= neg_q ? (32'd0 - quo) : quo;
          end
          done  <= 1'b1;
          state <= A_IDLE;
        end
        A_POW: begin
          if (expo == 32'd0) begin
            value <= acc;
            done  <= 1'b1;
            state <= A_IDLE;
          end else begin
            if (expo[0]) begin
              acc <= p_acc[31:0];
            end
            base <= p_base[31:0];
            expo <= {1'b0, expo[31:1]};
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  assign rsp.done  = done;
  assign rsp.value = value;

endmodule

>>> sv/rpn_stack_alu.sv
`timescale 1ns / 1ps
// rpn_stack_alu: top level of the 32-bit RPN stack calculator.
// Uses rsa_pkg, rsa_ram (stack memory) and rsa_alu (operation unit).
//
// Channel   Ports               Handshake
// -------   -----------------   ------------------------------------------
// command   start, busy, cmd    taken at an edge with start high, busy low
// result    done, res           done high for one cycle, never stalled
//
// Sequence: push, overflow, underflow and unused ops go from accept to S_DONE;
// unary ops pass S_ALU; binary ops pass S_RD and S_ALU (div/mod by zero skips S_ALU).
// The divide loop (one bit per cycle) and the power loop (one exponent bit
// per cycle) set the worst case; one transaction is in flight at a time.
// Reset clears the depth count and control; the stack memory is not
// cleared, since only entries pushed since reset are ever read.
// The result side cannot stall: res is valid exactly while done is high.
module rpn_stack_alu (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rsa_pkg::cmd_t cmd,
  output logic          done,
  output rsa_pkg::res_t res
);
  import rsa_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;  // second operand arriving from RAM
  localparam logic [1:0] S_ALU  = 2'd2;  // waiting on the operation unit
  localparam logic [1:0] S_DONE = 2'd3;  // load result register

  logic [1:0]       state;
  logic [CNT_W-1:0] count;    // entries on the stack
  logic [31:0]      topv;     // cached copy of the top entry
  logic [3:0]       op;
  logic [1:0]       status;

  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  logic              is_binary, accept;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [31:0]       wdata, rdata;
  alu_req_t          areq;
  alu_rsp_t          arsp;

  assign cnt_m1 = count - CNT_W'(1);
  assign cnt_m2 = count - CNT_W'(2);
  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  always_comb begin
    is_binary = 1'b0;
    case (op)
      OP_XOR, OP_OR, OP_AND, OP_MOD, OP_DIV,
      OP_MUL, OP_POW, OP_SUB, OP_ADD: is_binary = 1'b1;
      default: ;
    endcase
  end

  // stack memory: the second-from-top entry is read continuously, so it is
  // ready in the cycle after a command is taken; the top lives in topv
  rsa_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(cnt_m2[ADDR_W-1:0]),
    .rdata(rdata)
  );

  rsa_alu u_alu (
    .clk(clk),
    .rst(rst),
    .req(areq),
    .lhs(rdata),
    .rhs(topv),
    .rsp(arsp)
  );

  // memory writes (push in idle, write-back of the result when the unit is done) and unit requests
  always_comb begin
    we    = 1'b0;
    waddr = count[ADDR_W-1:0];
    wdata = cmd.literal;
    areq  = '0;
    if (accept && cmd.op == OP_PUSH && count != CNT_W'(STACK_DEPTH)) begin
      we = 1'b1;
    end
    if (accept && (cmd.op == OP_NOT || cmd.op == OP_INC || cmd.op == OP_DEC)
        && count != '0) begin
      areq.go = 1'b1;
      areq.op = cmd.op;
    end
    if (state == S_RD && !((op == OP_DIV || op == OP_MOD) && topv == 32'd0)) begin
      areq.go = 1'b1;
      areq.op = op;
    end
    if (state == S_ALU && arsp.done) begin
      we    = 1'b1;
      wdata = arsp.value;
      waddr = is_binary ? cnt_m2[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      status <= ST_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op     <= cmd.op;
            status <= ST_OK;
            state  <= S_DONE;
            case (cmd.op)
              OP_PUSH: begin
                if (count == CNT_W'(STACK_DEPTH)) begin
                  status <= ST_OVER;
                end else begin
                  topv  <= cmd.literal;
                  count <= count + CNT_W'(1);
                end
              end
              OP_NOT, OP_INC, OP_DEC: begin
                if (count == '0) begin
                  status <= ST_UNDER;
                end else begin
                  state <= S_ALU;
                end
              end
              OP_XOR, OP_OR, OP_AND, OP_MOD, OP_DIV,
              OP_MUL, OP_POW, OP_SUB, OP_ADD: begin
                if (count < CNT_W'(2)) begin
                  status <= ST_UNDER;
                end else begin
                  state <= S_RD;
                end
              end
              default: ;  // unused codes: no change
            endcase
          end
        end
        S_RD: begin
          if ((op == OP_DIV || op == OP_MOD) && topv == 32'd0) begin
            status <= ST_DIVZERO;
            state  <= S_DONE;
          end else begin
            state <= S_ALU;
          end
        end
        S_ALU: begin
          if (arsp.done) begin
            topv <= arsp.value;
            if (is_binary) begin
              count <= cnt_m1;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          res.top    <= (count == '0) ? 32'sd0 : topv;
          res.depth  <= count;
          res.status <= status;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/rsa_checker.sv
`timescale 1ns / 1ps
// rsa_checker: port-level assertions for rpn_stack_alu, bound to the top.
// Uses rsa_pkg.
module rsa_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input rsa_pkg::res_t res
);
  import rsa_pkg::*;

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised after command");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    (done && res.depth == 9'd0) |-> res.top == 32'sd0)
    else $error("nonzero top on empty stack");

  a_over_full: assert property (@(posedge clk) disable iff (rst)
    (done && res.status == ST_OVER) |-> res.depth == 9'(STACK_DEPTH))
    else $error("overflow reported with stack not full");

  a_under_shallow: assert property (@(posedge clk) disable iff (rst)
    (done && res.status == ST_UNDER) |-> res.depth < 9'd2)
    else $error("underflow reported with two or more entries");

endmodule

bind rpn_stack_alu rsa_checker u_rsa_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .res  (res)
);
